>>> rtl/core/bb3_pkg.sv
package bb3_pkg;

    // Register map and reset values
    localparam int unsigned CfgWidthW  = 11;
    localparam int unsigned CfgHeightW = 13;
    localparam int unsigned CfgDataW   = 13;
    localparam logic [CfgWidthW-1:0]  WidthReset  = 11'd640;
    localparam logic [CfgHeightW-1:0] HeightReset = 13'd480;
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Data widths: channel, pixel, column sum of three samples, window sum of nine
    localparam int unsigned ChanW   = 8;
    localparam int unsigned PixW    = 3 * ChanW;
    localparam int unsigned ColSumW = 10;
    localparam int unsigned SumW    = 12;

    // Reciprocals scaled by 2^16 for the rounded mean
    localparam int unsigned RecipW = 14;
    localparam logic [RecipW-1:0] Recip9 = 14'd7282;
    localparam logic [RecipW-1:0] Recip6 = 14'd10923;

    // Number of samples in the window
    typedef enum logic [1:0] {
        CNT_4,
        CNT_6,
        CNT_9
    } t_cnt;

    typedef logic [2:0][ColSumW-1:0] t_chsum;

    typedef struct packed {
        logic [2:0][SumW-1:0] sum;
        t_cnt                 cnt;
        logic                 last;
        logic                 fend;
    } t_job;

    // Up to two results caused by one item, first one in a
    typedef struct packed {
        logic a_vld;
        logic b_vld;
        t_job a;
        t_job b;
    } t_job_pair;

    function automatic t_cnt f_cnt(input logic rows3, input logic cols3);
        t_cnt c;
        if (rows3 && cols3) begin
            c = CNT_9;
        end else if (rows3 || cols3) begin
            c = CNT_6;
        end else begin
            c = CNT_4;
        end
        return c;
    endfunction

    // Mean rounded half up: (sum + cnt/2) / cnt; reciprocal multiply for 6 and 9, shift for 4
    function automatic logic [ChanW-1:0] f_div_round(input logic [SumW-1:0] sum,
                                                     input t_cnt cnt);
        logic [SumW-1:0]        x;
        logic [SumW+RecipW-1:0] prod;
        logic [ChanW-1:0]       q;
        x    = sum;
        prod = '0;
        q    = '0;
        case (cnt)
            CNT_9: begin
                x    = sum + SumW'(4);
                prod = (SumW+RecipW)'(x) * (SumW+RecipW)'(Recip9);
                q    = prod[16 +: ChanW];
            end
            CNT_6: begin
                x    = sum + SumW'(3);
                prod = (SumW+RecipW)'(x) * (SumW+RecipW)'(Recip6);
                q    = prod[16 +: ChanW];
            end
            default: begin
                x = sum + SumW'(2);
                q = x[2 +: ChanW];
            end
        endcase
        return q;
    endfunction

endpackage

>>> rtl/core/box_blur_3x3_rgb_core.sv
// Path: results wait in the result slots, then are divided into the output register.
// Throughput: one item per cycle unless the output stalls; a pixel in the last column
// of a row (second row on) gives two results through the single output register.
// The line memory is one read and one write per cycle, which sets that rate.
// Reset: counters cleared, width 640 and height 480; line memory is not cleared.
module box_blur_3x3_rgb_core
    import bb3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // Pixel items in
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PixW-1:0]     s_axis_tdata,   // in_red, in_green, in_blue
    input  logic                s_axis_tuser,   // opcode
    // Blurred pixels out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PixW-1:0]     m_axis_tdata,   // out_red, out_green, out_blue
    output logic                m_axis_tlast,
    output logic                m_axis_tuser    // frame_end
);

    logic      cfg_we;
    logic      accept;
    t_job_pair jobs;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign accept      = s_axis_tvalid && s_axis_tready;

    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_opcode    (s_axis_tuser),
        .i_pixel     (s_axis_tdata),
        .o_jobs      (jobs)
    );

    bb3_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_jobs  (jobs),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_fend  (m_axis_tuser)
    );

endmodule

>>> rtl/core/bb3_ram.sv
module bb3_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bb3_front.sv
module bb3_front
    import bb3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_accept,
    input  logic                i_opcode,
    input  logic [PixW-1:0]     i_pixel,
    output t_job_pair           o_jobs
);

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMPW = (WW > CfgWidthW) ? WW : CfgWidthW;

    // Configuration and counters
    logic [CfgWidthW-1:0]  r_img_width,  n_img_width;
    logic [CfgHeightW-1:0] r_img_height, n_img_height;
    logic [CW-1:0]         r_col,   n_col;
    logic [CfgHeightW-1:0] r_row,   n_row;
    logic [WW-1:0]         r_drain, n_drain;
    logic [CW-1:0]         r_dcol,  n_dcol;

    // Window held as per-column channel sums, oldest column first
    logic [2:0][2:0][ColSumW-1:0] r_cs, n_cs;
    t_chsum r_head0, n_head0;
    t_chsum r_head1, n_head1;

    // Line memory: above row in the upper half, row two above in the lower half
    logic [2*PixW-1:0] ram_rdata;
    logic [2*PixW-1:0] wdata;
    logic              we;
    logic [CW-1:0]     raddr;
    logic              r_byp;
    logic [2*PixW-1:0] r_byp_data;

    logic [2*PixW-1:0] rd;
    logic [PixW-1:0]   above;
    logic [PixW-1:0]   two;

    logic [CMPW-1:0]       width_ext;
    logic [WW-1:0]         w_eff;
    logic [CfgHeightW-1:0] h_eff;
    logic                  last_col;
    logic                  last_row;
    logic                  row_ge1;
    logic                  row_ge2;
    logic                  col_ge1;
    logic                  col_ge2;
    logic                  col_is1;
    logic                  drn_cv0;
    logic                  drn_cv2;
    logic                  drain_act;

    t_chsum cs_pix;
    t_chsum cs_drn;
    t_chsum head_now;
    t_job   pix_a;
    t_job   pix_b;
    t_job   drn_a;

    // Effective frame size
    always_comb begin
        width_ext = CMPW'(r_img_width);
        if (width_ext < CMPW'(2)) begin
            w_eff = WW'(2);
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_ext);
        end
        h_eff = (r_img_height < CfgHeightW'(2)) ? CfgHeightW'(2) : r_img_height;
    end

    assign last_col  = (WW'(r_col) == w_eff - WW'(1));
    assign last_row  = (r_row == h_eff - CfgHeightW'(1));
    assign row_ge1   = (r_row != '0);
    assign row_ge2   = (r_row[CfgHeightW-1:1] != '0);
    assign col_ge1   = (r_col != '0);
    assign col_ge2   = (WW'(r_col) > WW'(1));
    assign col_is1   = (r_col == CW'(1));
    assign drn_cv0   = (r_dcol != '0);
    assign drn_cv2   = (r_drain != WW'(1));
    assign drain_act = (i_opcode == OP_DRAIN) && (r_drain != '0);

    // Take the line data, forwarding a write to the same address
    assign rd    = r_byp ? r_byp_data : ram_rdata;
    assign above = rd[PixW +: PixW];
    assign two   = rd[0 +: PixW];

    // Column sums of the newly read column
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cs_pix[ch] = ColSumW'(i_pixel[ch*ChanW +: ChanW])
                       + ColSumW'(above[ch*ChanW +: ChanW])
                       + (row_ge2 ? ColSumW'(two[ch*ChanW +: ChanW]) : '0);
            cs_drn[ch] = ColSumW'(above[ch*ChanW +: ChanW])
                       + ColSumW'(two[ch*ChanW +: ChanW]);
            head_now[ch] = ColSumW'(i_pixel[ch*ChanW +: ChanW])
                         + ColSumW'(above[ch*ChanW +: ChanW]);
        end
    end

    // Build the results of the current item
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            pix_a.sum[ch] = (col_ge2 ? SumW'(r_cs[1][ch]) : '0)
                          + SumW'(r_cs[2][ch]) + SumW'(cs_pix[ch]);
            pix_b.sum[ch] = SumW'(r_cs[2][ch]) + SumW'(cs_pix[ch]);
            drn_a.sum[ch] = (drn_cv0 ? SumW'(r_cs[0][ch]) : '0)
                          + SumW'(r_cs[1][ch])
                          + (drn_cv2 ? SumW'(r_cs[2][ch]) : '0);
        end
        pix_a.cnt  = f_cnt(row_ge2, col_ge2);
        pix_a.last = !last_col;
        pix_a.fend = 1'b0;
        pix_b.cnt  = f_cnt(row_ge2, 1'b0);
        pix_b.last = 1'b1;
        pix_b.fend = 1'b0;
        drn_a.cnt  = f_cnt(1'b0, drn_cv0 && drn_cv2);
        drn_a.last = 1'b1;
        drn_a.fend = (r_drain == WW'(1));

        if (i_opcode == OP_DRAIN) begin
            o_jobs.a_vld = drain_act;
            o_jobs.a     = drn_a;
        end else begin
            o_jobs.a_vld = row_ge1 && col_ge1;
            o_jobs.a     = pix_a;
        end
        o_jobs.b_vld = (i_opcode == OP_PIXEL) && row_ge1 && last_col;
        o_jobs.b     = pix_b;
    end

    // Next state
    always_comb begin
        n_img_width  = r_img_width;
        n_img_height = r_img_height;
        n_col        = r_col;
        n_row        = r_row;
        n_drain      = r_drain;
        n_dcol       = r_dcol;
        n_cs         = r_cs;
        n_head0      = r_head0;
        n_head1      = r_head1;
        we           = 1'b0;
        wdata        = {i_pixel, above};

        if (i_cfg_we) begin
            // Write a register and restart the frame
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_img_width  = i_cfg_data[CfgWidthW-1:0];
                CFG_IMAGE_HEIGHT: n_img_height = i_cfg_data[CfgHeightW-1:0];
            endcase
            n_col   = '0;
            n_row   = '0;
            n_drain = '0;
            n_dcol  = '0;
        end else if (i_accept) begin
            if (i_opcode == OP_DRAIN) begin
                // Advance the drain window along the last row
                if (drain_act) begin
                    n_drain = r_drain - WW'(1);
                    n_dcol  = r_dcol + CW'(1);
                    n_cs[0] = r_cs[1];
                    n_cs[1] = r_cs[2];
                    n_cs[2] = cs_drn;
                end
            end else begin
                // Pixel: update line memory, slide the window, step the raster
                we      = 1'b1;
                n_drain = '0;
                n_dcol  = '0;
                n_cs[0] = r_cs[1];
                n_cs[1] = r_cs[2];
                n_cs[2] = cs_pix;
                if (r_col == '0) begin
                    n_head0 = head_now;
                end
                if (col_is1) begin
                    n_head1 = head_now;
                end
                if (last_col) begin
                    n_col = '0;
                    if (last_row) begin
                        // Frame done: preload the first two columns for the drain
                        n_row   = '0;
                        n_drain = w_eff;
                        n_cs[1] = r_head0;
                        n_cs[2] = col_is1 ? head_now : r_head1;
                    end else begin
                        n_row = r_row + CfgHeightW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end

        // Fetch the column needed by the next item
        if (n_drain != '0) begin
            raddr = n_dcol + CW'(2);
        end else begin
            raddr = n_col;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= WidthReset;
            r_img_height <= HeightReset;
            r_col        <= '0;
            r_row        <= '0;
            r_drain      <= '0;
            r_dcol       <= '0;
            r_byp        <= 1'b0;
        end else begin
            r_img_width  <= n_img_width;
            r_img_height <= n_img_height;
            r_col        <= n_col;
            r_row        <= n_row;
            r_drain      <= n_drain;
            r_dcol       <= n_dcol;
            r_byp        <= we && (raddr == r_col);
        end
    end

    // Window and forwarding data
    always_ff @(posedge i_clk) begin
        r_cs       <= n_cs;
        r_head0    <= n_head0;
        r_head1    <= n_head1;
        r_byp_data <= wdata;
    end

    bb3_ram #(
        .WIDTH (2 * PixW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_col),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

endmodule

>>> rtl/core/bb3_out.sv
module bb3_out
    import bb3_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  t_job_pair       i_jobs,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [PixW-1:0] o_data,
    output logic            o_last,
    output logic            o_fend
);

    logic      r_a_vld, n_a_vld;
    logic      r_b_vld, n_b_vld;
    t_job      r_a;
    t_job      r_b;
    logic      r_o_vld, n_o_vld;
    logic [PixW-1:0] r_o_data, n_o_data;
    logic      r_o_last;
    logic      r_o_fend;

    logic      take;
    logic      pop_a;
    logic      pop_b;
    t_job      sel;

    // Hand results to the output register one per cycle while it can take them, a before b
    assign take  = !r_o_vld || i_ready;
    assign pop_a = take && r_a_vld;
    assign pop_b = take && !r_a_vld && r_b_vld;
    assign sel   = r_a_vld ? r_a : r_b;

    // Take a new item when the result slots will be empty after this cycle
    assign o_ready = (!r_a_vld && !r_b_vld) || (take && !(r_a_vld && r_b_vld));

    always_comb begin
        n_a_vld = i_accept ? i_jobs.a_vld : (r_a_vld && !pop_a);
        n_b_vld = i_accept ? i_jobs.b_vld : (r_b_vld && !pop_b);
        if (pop_a || pop_b) begin
            n_o_vld = 1'b1;
        end else if (take) begin
            n_o_vld = 1'b0;
        end else begin
            n_o_vld = r_o_vld;
        end
        // Divide the window sums
        for (int ch = 0; ch < 3; ch++) begin
            n_o_data[ch*ChanW +: ChanW] = f_div_round(sel.sum[ch], sel.cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a <= i_jobs.a;
            r_b <= i_jobs.b;
        end
        if (pop_a || pop_b) begin
            r_o_data <= n_o_data;
            r_o_last <= sel.last;
            r_o_fend <= sel.fend;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;
    assign o_fend  = r_o_fend;

endmodule

>>> bench/box_blur_checker.sv
module box_blur_checker
    import bb3_pkg::*;
#(
    parameter int unsigned MaxWidth = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Register writes
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // Pixel items into the block
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [PixW-1:0]     i_in_data,    // in_red, in_green, in_blue
    input  logic                i_in_user,    // opcode
    // Blurred pixels out of the block
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [PixW-1:0]     i_out_data,   // out_red, out_green, out_blue
    input  logic                i_out_last,
    input  logic                i_out_user,   // frame_end
    output int                  o_mismatches,
    output int                  o_pending
);

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic             last;
        logic             fend;
    } t_blur_px;

    // Own copy of the block state; pixels are kept as they travel in tdata
    logic [PixW-1:0]      row_above     [MaxWidth];
    logic [PixW-1:0]      row_two_above [MaxWidth];
    logic [8:0][PixW-1:0] window_px;
    int unsigned          col_cnt;
    int unsigned          row_cnt;
    int unsigned          drain_cnt;
    int unsigned          width_reg;
    int unsigned          height_reg;

    t_blur_px blurred_q[$];

    function automatic void clear_state();
        for (int i = 0; i < MaxWidth; i++) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
        end
        window_px  = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        drain_cnt  = 0;
        width_reg  = 32'(WidthReset);
        height_reg = 32'(HeightReset);
        blurred_q.delete();
    endfunction

    // Average the valid part of a 3x3 neighborhood, rounded half up, and queue it
    function automatic void push_mean(input logic [8:0][PixW-1:0] px,
                                      input logic [2:0] rv, input logic [2:0] cv,
                                      input logic last, input logic fend);
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int unsigned cnt;
        t_blur_px    res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt   = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (rv[i] && cv[j]) begin
                    sum_r += 32'(px[i*3+j][0 +: ChanW]);
                    sum_g += 32'(px[i*3+j][ChanW +: ChanW]);
                    sum_b += 32'(px[i*3+j][2*ChanW +: ChanW]);
                    cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        res.red   = ChanW'((sum_r + cnt / 2) / cnt);
        res.green = ChanW'((sum_g + cnt / 2) / cnt);
        res.blue  = ChanW'((sum_b + cnt / 2) / cnt);
        res.last  = last;
        res.fend  = fend;
        blurred_q.push_back(res);
    endfunction

    // Advance the blur state by one item and queue the pixels it releases
    function automatic void blur_step(input logic op, input logic [PixW-1:0] pix);
        int unsigned          w;
        int unsigned          h;
        int unsigned          c;
        int unsigned          r;
        int unsigned          d;
        logic [8:0][PixW-1:0] px;
        logic [2:0]           rv;
        logic [2:0]           cv;
        logic                 last_col;
        w = (width_reg < 2) ? 2 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
        h = (height_reg < 2) ? 2 : height_reg;

        // Drain: emit one pixel of the final row, bottom row of window out of frame
        if (op == OP_DRAIN) begin
            if (drain_cnt == 0 || drain_cnt > w) begin
                drain_cnt = 0;
                return;
            end
            d     = w - drain_cnt;
            px    = '0;
            rv    = 3'b011;
            cv[0] = (d >= 1);
            cv[1] = 1'b1;
            cv[2] = (d + 1 < w);
            if (cv[0]) begin
                px[0] = row_two_above[d-1];
                px[3] = row_above[d-1];
            end
            px[1] = row_two_above[d];
            px[4] = row_above[d];
            if (cv[2]) begin
                px[2] = row_two_above[d+1];
                px[5] = row_above[d+1];
            end
            drain_cnt--;
            push_mean(px, rv, cv, 1'b1, drain_cnt == 0);
            return;
        end

        // Pixel: drop pending drains, shift the window and update the line stores
        drain_cnt = 0;
        c = col_cnt;
        r = row_cnt;
        if (c >= w) c = 0;
        for (int i = 0; i < 3; i++) begin
            window_px[i*3]   = window_px[i*3+1];
            window_px[i*3+1] = window_px[i*3+2];
        end
        window_px[2]     = row_two_above[c];
        window_px[5]     = row_above[c];
        window_px[8]     = pix;
        row_two_above[c] = row_above[c];
        row_above[c]     = pix;

        if (r >= 1) begin
            rv[0]    = (r >= 2);
            rv[1]    = 1'b1;
            rv[2]    = 1'b1;
            last_col = (c + 1 == w);
            if (c >= 1) begin
                cv[0] = (c >= 2);
                cv[1] = 1'b1;
                cv[2] = 1'b1;
                push_mean(window_px, rv, cv, !last_col, 1'b0);
            end
            // Right edge pixel of the row above comes out right behind
            if (last_col) begin
                for (int i = 0; i < 3; i++) begin
                    px[i*3]   = window_px[i*3+1];
                    px[i*3+1] = window_px[i*3+2];
                    px[i*3+2] = '0;
                end
                cv = 3'b011;
                push_mean(px, rv, cv, 1'b1, 1'b0);
            end
        end

        if (c + 1 >= w) begin
            c = 0;
            if (r + 1 >= h) begin
                r         = 0;
                drain_cnt = w;
            end else begin
                r++;
            end
        end else begin
            c++;
        end
        col_cnt = c;
        row_cnt = r;
    endfunction

    // Compare one accepted output item against the oldest prediction
    function automatic void check_blurred();
        t_blur_px want;
        if (blurred_q.size() == 0) begin
            $error("blurred pixel with nothing predicted: tdata %h tlast %b tuser %b",
                   i_out_data, i_out_last, i_out_user);
            o_mismatches++;
            return;
        end
        want = blurred_q.pop_front();
        if (i_out_data[0 +: ChanW] !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, i_out_data[0 +: ChanW]);
            o_mismatches++;
        end
        if (i_out_data[ChanW +: ChanW] !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green,
                   i_out_data[ChanW +: ChanW]);
            o_mismatches++;
        end
        if (i_out_data[2*ChanW +: ChanW] !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue,
                   i_out_data[2*ChanW +: ChanW]);
            o_mismatches++;
        end
        if (i_out_last !== want.last) begin
            $error("last_in_run: expected %0d, got %0d", want.last, i_out_last);
            o_mismatches++;
        end
        if (i_out_user !== want.fend) begin
            $error("frame_end: expected %0d, got %0d", want.fend, i_out_user);
            o_mismatches++;
        end
    endfunction

    // Watch all three channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                    width_reg = 32'(i_cfg_data[CfgWidthW-1:0]);
                end else begin
                    height_reg = 32'(i_cfg_data[CfgHeightW-1:0]);
                end
                col_cnt   = 0;
                row_cnt   = 0;
                drain_cnt = 0;
            end
            if (i_in_valid && i_in_ready) begin
                blur_step(i_in_user, i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_blurred();
            end
        end
        o_pending = blurred_q.size();
    end

endmodule

>>> bench/box_blur_3x3_rgb_core_tb.sv
module box_blur_3x3_rgb_core_tb;
    import bb3_pkg::*;

    localparam int unsigned MaxWidth   = 1024;
    localparam int unsigned RandItems  = 200;
    localparam int unsigned CycleLimit = 800000;
    localparam int unsigned LongHold   = 600;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index   = CFG_IMAGE_WIDTH;
    logic [CfgDataW-1:0] i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [PixW-1:0]     s_axis_tdata  = '0;
    logic                s_axis_tuser  = OP_PIXEL;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [PixW-1:0]     m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;

    int mismatches;
    int blur_pending;

    // Frame geometry as the block sees it after clamping
    int fw;
    int fh;
    int frame_items;
    int burst_left;
    int cycle_count;

    // Receiver pattern state
    bit rx_hold_req;
    int rx_hold_left;
    int rx_mode;
    int rx_mode_left;
    int rx_tick;

    box_blur_3x3_rgb_core #(
        .MAX_WIDTH(MaxWidth)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    box_blur_checker #(
        .MaxWidth(MaxWidth)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (blur_pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: switch among stall patterns, honor a requested long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = LongHold;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_tick++;
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    // Offer one item, with bursts and random gaps in between
    task automatic offer(input logic op, input logic [PixW-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold the sender until every predicted pixel is out, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (blur_pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Write both geometry registers in random order; spare data bits of width are junk
    task automatic set_geometry(input int w, input int h);
        logic [CfgDataW-1:0] wdata;
        logic [CfgDataW-1:0] hdata;
        wdata = {2'($urandom_range(0, 3)), 11'(w)};
        hdata = CfgDataW'(h);
        settle();
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_IMAGE_WIDTH, wdata);
            write_reg(CFG_IMAGE_HEIGHT, hdata);
        end else begin
            write_reg(CFG_IMAGE_HEIGHT, hdata);
            write_reg(CFG_IMAGE_WIDTH, wdata);
        end
        fw = (w < 2) ? 2 : ((w > MaxWidth) ? MaxWidth : w);
        fh = (h < 2) ? 2 : h;
    endtask

    // Send rows of random pixels, then drains; noise drains mid-frame are ignored
    task automatic send_frame(input int rows, input int drains, input bit noisy);
        for (int i = 0; i < rows * fw; i++) begin
            if (noisy && i != 0 && $urandom_range(0, 15) == 0) begin
                offer(OP_DRAIN, PixW'($urandom()));
            end
            offer(OP_PIXEL, PixW'($urandom()));
        end
        for (int i = 0; i < drains; i++) begin
            offer(OP_DRAIN, PixW'($urandom()));
        end
        frame_items += rows * fw + drains;
    endtask

    initial begin
        int w;
        int h;
        int rows;
        int drains;
        int nframes;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: nothing pending yet, and the first pixels of row 0 give nothing
        fw = 640;
        fh = 480;
        offer(OP_DRAIN, '0);
        for (int i = 0; i < 8; i++) begin
            offer(OP_PIXEL, PixW'($urandom()));
        end

        // Width and height below range act as 2; corner pixels at channel extremes
        set_geometry(1, 0);
        offer(OP_PIXEL, 24'h000000);
        offer(OP_PIXEL, 24'hffffff);
        offer(OP_PIXEL, 24'hff00ff);
        offer(OP_PIXEL, 24'h00ff00);
        offer(OP_DRAIN, 24'hffffff);
        offer(OP_DRAIN, 24'h000000);
        offer(OP_DRAIN, 24'h000000);

        // Drop pending drains with a new pixel
        set_geometry(0, 1);
        offer(OP_PIXEL, 24'hffffff);
        offer(OP_PIXEL, 24'hffffff);
        offer(OP_PIXEL, 24'hffffff);
        offer(OP_PIXEL, 24'hfffffe);
        offer(OP_DRAIN, 24'h000000);
        offer(OP_PIXEL, 24'h0000ff);
        offer(OP_PIXEL, 24'h00ff00);
        offer(OP_PIXEL, 24'hff0000);
        offer(OP_PIXEL, 24'h010101);
        offer(OP_DRAIN, 24'h000000);
        offer(OP_DRAIN, 24'h000000);

        // Width above range clamps to the line length; long receiver hold-off
        set_geometry(2047, 2);
        rx_hold_req = 1'b1;
        for (int i = 0; i < MaxWidth + 4; i++) begin
            offer(OP_PIXEL, PixW'($urandom()));
        end

        // Top height values, partial frames cut off by the next write
        set_geometry(2, 8191);
        send_frame(7, 0, 1'b1);
        set_geometry(3, 4096);
        send_frame(5, 0, 1'b1);

        // Random geometries, mostly small whole frames
        frame_items = 0;
        while (frame_items < RandItems) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);
                1:       w = $urandom_range(10, 24);
                default: w = $urandom_range(2, 9);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 1);
                1:       h = $urandom_range(6, 10);
                2:       h = $urandom_range(4096, 8191);
                default: h = $urandom_range(2, 5);
            endcase
            set_geometry(w, h);
            nframes = (fh > 12) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                rows = (fh > 12) ? $urandom_range(1, 3) : fh;
                case ($urandom_range(0, 9))
                    6:       drains = fw + 1;
                    7, 8:    drains = $urandom_range(1, fw - 1);
                    9:       drains = 0;
                    default: drains = fw;
                endcase
                if (rows < fh) drains = 0;
                send_frame(rows, drains, $urandom_range(0, 2) == 0);
                if ($urandom_range(0, 5) == 0) settle();
            end
        end

        // Drain out and give the verdict
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (blur_pending == 0);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_ram.sv
rtl/core/bb3_front.sv
rtl/core/bb3_out.sv
rtl/core/box_blur_3x3_rgb_core.sv
bench/box_blur_checker.sv
bench/box_blur_3x3_rgb_core_tb.sv
